/* rtl/spdpid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed PID duty controller package
// Shared widths, state and register codes of the speed PID duty controller.
// ----------------------------------------------------------------------------
package spdpid_pkg;

   // Field widths
   localparam int SPEED_W    = 15;
   localparam int ERR_W      = 16;
   localparam int DERR_W     = 17;
   localparam int GAIN_W     = 16;
   localparam int SHIFT_W    = 5;
   localparam int DUTY_W     = 8;
   localparam int LIMIT_W    = 31;
   localparam int INTEG_W    = 32;

   // Bit-serial multiplier: signed multiplicand, unsigned multiplier
   localparam int MCAND_W    = 32;
   localparam int MPLR_W     = 16;
   localparam int PROD_W     = MCAND_W + MPLR_W;
   localparam int MUL_STEPS  = MPLR_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

   // Digit-serial divider: two quotient bits per cycle
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 15;
   localparam int DIV_DIGIT  = 2;
   localparam int DIV_CYCLES = DIVIDEND_W / DIV_DIGIT;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   // Accumulator and sum widths
   localparam int ACC_W      = 34;
   localparam int SUM_W      = 50;
   localparam int MAG_W      = SUM_W - 1;

   // Register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RESET   = SHIFT_W'(8);
   localparam logic [DUTY_W-1:0]  DUTY_CEILING_RESET = DUTY_W'(255);

   typedef enum logic [2:0] {
      REG_GAIN_PROP,
      REG_GAIN_INTEGRAL,
      REG_GAIN_DERIV,
      REG_FRAC_SHIFT,
      REG_DUTY_FLOOR,
      REG_DUTY_CEILING,
      REG_MIN_GOAL_SPEED,
      REG_INTEGRAL_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_CLAMP,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_SUM,
      ST_FINISH
   } state_type;

endpackage

/* rtl/spdpid_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module spdpid_mul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [spdpid_pkg::MCAND_W-1:0]   multiplicand,
   input  logic        [spdpid_pkg::MPLR_W-1:0]    multiplier,
   output logic                                    done,
   output logic signed [spdpid_pkg::PROD_W-1:0]    product
);

   logic signed [spdpid_pkg::MCAND_W-1:0]  hi_ff, hi_in;
   logic        [spdpid_pkg::MPLR_W-1:0]   lo_ff, lo_in;
   logic signed [spdpid_pkg::MCAND_W-1:0]  mcand_ff, mcand_in;
   logic        [spdpid_pkg::MUL_CNT_W-1:0] count_ff, count_in;
   logic signed [spdpid_pkg::MCAND_W-1:0]  addend;
   logic signed [spdpid_pkg::MCAND_W:0]    partial;

   // Add the multiplicand when the low bit is set, then shift the pair right.
   always_comb begin
      addend  = lo_ff[0] ? mcand_ff : '0;
      partial = {hi_ff[spdpid_pkg::MCAND_W-1], hi_ff}
              + {addend[spdpid_pkg::MCAND_W-1], addend};
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      count_in = count_ff;
      if (start) begin
         hi_in    = '0;
         lo_in    = multiplier;
         mcand_in = multiplicand;
         count_in = spdpid_pkg::MUL_CNT_W'(spdpid_pkg::MUL_STEPS);
      end else if (count_ff != '0) begin
         hi_in    = partial[spdpid_pkg::MCAND_W:1];
         lo_in    = {partial[0], lo_ff[spdpid_pkg::MPLR_W-1:1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign done    = (count_ff == '0);
   assign product = {hi_ff, lo_ff};

endmodule

/* rtl/spdpid_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-serial divider
// Unsigned restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module spdpid_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [spdpid_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [spdpid_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                   done,
   output logic [spdpid_pkg::DIVIDEND_W-1:0]      quotient
);

   logic [spdpid_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [spdpid_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [spdpid_pkg::DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [spdpid_pkg::DIV_CNT_W-1:0]  count_ff, count_in;

   // The quotient register starts out holding the dividend; its top bit moves
   // into the remainder while each new quotient bit enters at the bottom.
   always_comb begin
      logic [spdpid_pkg::DIVISOR_W-1:0]  rem_v;
      logic [spdpid_pkg::DIVIDEND_W-1:0] quo_v;
      logic [spdpid_pkg::DIVISOR_W:0]    trial;
      logic                              qbit;
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int k = 0; k < spdpid_pkg::DIV_DIGIT; k++) begin
         trial = {rem_v, quo_v[spdpid_pkg::DIVIDEND_W-1]};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_v = spdpid_pkg::DIVISOR_W'(trial - {1'b0, divisor_ff});
            qbit  = 1'b1;
         end else begin
            rem_v = trial[spdpid_pkg::DIVISOR_W-1:0];
            qbit  = 1'b0;
         end
         quo_v = {quo_v[spdpid_pkg::DIVIDEND_W-2:0], qbit};
      end

      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         count_in   = spdpid_pkg::DIV_CNT_W'(spdpid_pkg::DIV_CYCLES);
      end else if (count_ff != '0) begin
         rem_in   = rem_v;
         quo_in   = quo_v;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = (count_ff == '0);
   assign quotient = quo_ff;

endmodule

/* rtl/speed_pid_duty_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed PID duty controller core
// PID speed loop with integral anti-windup that turns speed samples into an
// 8-bit PWM duty.
// ----------------------------------------------------------------------------
// Usage
// Each item on the req_ channel carries a goal speed, a measured speed and a
// time step. For every item the rsp_ channel delivers exactly one item with a
// duty value and a motor stop flag, in order. Both channels use valid/ready.
// Gains, shift, duty bounds, stop threshold and integral limit sit in an
// APB-style register file (register i at byte address 4*i, pready always
// high); write them only while the controller is idle.
// A running item first passes through the three bit-serial multipliers (one
// multiplier bit per cycle), then the integral clamp, then the radix-4 divider
// for the derivative term, which overlaps the bit-serial integral multiply,
// and last the summing and output steps. A stop item (goal at or below the
// threshold) needs no arithmetic and goes straight to the output step.
// One item is worked on at a time; a new item is taken while the previous
// result still waits in the output register. If the receiver stalls, the
// finished item waits in the last step until the output register frees up.
// Reset clears the integral, the previous error and the output valid flag, and
// puts the registers at their defaults; the block takes items the cycle after.
// ----------------------------------------------------------------------------
module speed_pid_duty_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [spdpid_pkg::SPEED_W-1:0]         req_goal_speed,
   input  logic [spdpid_pkg::SPEED_W-1:0]         req_measured_speed,
   input  logic [spdpid_pkg::SPEED_W-1:0]         req_time_step,
   // Result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [spdpid_pkg::DUTY_W-1:0]          rsp_duty,
   output logic                                   rsp_motor_stop,
   // Register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [spdpid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [spdpid_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [spdpid_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [spdpid_pkg::GAIN_W-1:0]   gain_prop_ff;
   logic [spdpid_pkg::GAIN_W-1:0]   gain_integral_ff;
   logic [spdpid_pkg::GAIN_W-1:0]   gain_deriv_ff;
   logic [spdpid_pkg::SHIFT_W-1:0]  frac_shift_ff;
   logic [spdpid_pkg::DUTY_W-1:0]   duty_floor_ff;
   logic [spdpid_pkg::DUTY_W-1:0]   duty_ceiling_ff;
   logic [spdpid_pkg::SPEED_W-1:0]  min_goal_speed_ff;
   logic [spdpid_pkg::LIMIT_W-1:0]  integral_limit_ff;

   logic                            csr_write;
   spdpid_pkg::csr_index_type       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = spdpid_pkg::csr_index_type'(csr_paddr[spdpid_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff      <= '0;
         gain_integral_ff  <= '0;
         gain_deriv_ff     <= '0;
         frac_shift_ff     <= spdpid_pkg::FRAC_SHIFT_RESET;
         duty_floor_ff     <= '0;
         duty_ceiling_ff   <= spdpid_pkg::DUTY_CEILING_RESET;
         min_goal_speed_ff <= '0;
         integral_limit_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            spdpid_pkg::REG_GAIN_PROP:
               gain_prop_ff <= csr_pwdata[spdpid_pkg::GAIN_W-1:0];
            spdpid_pkg::REG_GAIN_INTEGRAL:
               gain_integral_ff <= csr_pwdata[spdpid_pkg::GAIN_W-1:0];
            spdpid_pkg::REG_GAIN_DERIV:
               gain_deriv_ff <= csr_pwdata[spdpid_pkg::GAIN_W-1:0];
            spdpid_pkg::REG_FRAC_SHIFT:
               frac_shift_ff <= csr_pwdata[spdpid_pkg::SHIFT_W-1:0];
            spdpid_pkg::REG_DUTY_FLOOR:
               duty_floor_ff <= csr_pwdata[spdpid_pkg::DUTY_W-1:0];
            spdpid_pkg::REG_DUTY_CEILING:
               duty_ceiling_ff <= csr_pwdata[spdpid_pkg::DUTY_W-1:0];
            spdpid_pkg::REG_MIN_GOAL_SPEED:
               min_goal_speed_ff <= csr_pwdata[spdpid_pkg::SPEED_W-1:0];
            spdpid_pkg::REG_INTEGRAL_LIMIT:
               integral_limit_ff <= csr_pwdata[spdpid_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback, zero extended to the bus width.
   always_comb begin
      case (csr_index)
         spdpid_pkg::REG_GAIN_PROP:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(gain_prop_ff);
         spdpid_pkg::REG_GAIN_INTEGRAL:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(gain_integral_ff);
         spdpid_pkg::REG_GAIN_DERIV:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(gain_deriv_ff);
         spdpid_pkg::REG_FRAC_SHIFT:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(frac_shift_ff);
         spdpid_pkg::REG_DUTY_FLOOR:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(duty_floor_ff);
         spdpid_pkg::REG_DUTY_CEILING:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(duty_ceiling_ff);
         spdpid_pkg::REG_MIN_GOAL_SPEED:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(min_goal_speed_ff);
         spdpid_pkg::REG_INTEGRAL_LIMIT:
            csr_prdata = spdpid_pkg::CSR_DATA_W'(integral_limit_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   spdpid_pkg::state_type state_ff, state_in;

   logic accept;
   logic out_free;
   logic mul_go;
   logic final_go;
   logic clear_en;
   logic clamp_en;
   logic sum_en;
   logic load_out;

   logic mul_a_done, mul_b_done, mul_c_done, div_done;
   logic stop_ff, stop_in;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spdpid_pkg::ST_IDLE:
            if (req_valid) state_in = spdpid_pkg::ST_START;
         spdpid_pkg::ST_START:
            state_in = stop_ff ? spdpid_pkg::ST_FINISH : spdpid_pkg::ST_MUL;
         spdpid_pkg::ST_MUL:
            if (mul_a_done && mul_b_done && mul_c_done) state_in = spdpid_pkg::ST_CLAMP;
         spdpid_pkg::ST_CLAMP:
            state_in = spdpid_pkg::ST_LAUNCH;
         spdpid_pkg::ST_LAUNCH:
            state_in = spdpid_pkg::ST_DIVIDE;
         spdpid_pkg::ST_DIVIDE:
            if (div_done && mul_a_done) state_in = spdpid_pkg::ST_SUM;
         spdpid_pkg::ST_SUM:
            state_in = spdpid_pkg::ST_FINISH;
         spdpid_pkg::ST_FINISH:
            if (out_free) state_in = spdpid_pkg::ST_IDLE;
         default:
            state_in = spdpid_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_go    = 1'b0;
      final_go  = 1'b0;
      clear_en  = 1'b0;
      clamp_en  = 1'b0;
      sum_en    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         spdpid_pkg::ST_IDLE:   req_ready = 1'b1;
         spdpid_pkg::ST_START: begin
            mul_go   = ~stop_ff;
            clear_en = stop_ff;
         end
         spdpid_pkg::ST_MUL:    ;
         spdpid_pkg::ST_CLAMP:  clamp_en = 1'b1;
         spdpid_pkg::ST_LAUNCH: final_go = 1'b1;
         spdpid_pkg::ST_DIVIDE: ;
         spdpid_pkg::ST_SUM:    sum_en = 1'b1;
         spdpid_pkg::ST_FINISH: load_out = out_free;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Item capture
   // ------------------------------------------------------------------
   logic signed [spdpid_pkg::ERR_W-1:0]   err_ff, err_in;
   logic        [spdpid_pkg::SPEED_W-1:0] dt_ff, dt_in;

   always_comb begin
      err_in  = err_ff;
      dt_in   = dt_ff;
      stop_in = stop_ff;
      if (accept) begin
         err_in  = {1'b0, req_goal_speed} - {1'b0, req_measured_speed};
         dt_in   = req_time_step;
         stop_in = (req_goal_speed <= min_goal_speed_ff);
      end
   end

   // ------------------------------------------------------------------
   // Multipliers. Unit A first forms error * dt, then the integral term;
   // unit B the proportional term; unit C the derivative numerator.
   // ------------------------------------------------------------------
   logic signed [spdpid_pkg::INTEG_W-1:0]  integral_ff, integral_in;
   logic signed [spdpid_pkg::ERR_W-1:0]    last_error_ff, last_error_in;
   logic signed [spdpid_pkg::DERR_W-1:0]   derr;
   logic signed [spdpid_pkg::MCAND_W-1:0]  err_ext;
   logic signed [spdpid_pkg::MCAND_W-1:0]  derr_ext;
   logic signed [spdpid_pkg::MCAND_W-1:0]  mul_a_mcand;
   logic        [spdpid_pkg::MPLR_W-1:0]   mul_a_mplr;
   logic signed [spdpid_pkg::PROD_W-1:0]   prod_a, prod_b, prod_c;

   assign derr     = {err_ff[spdpid_pkg::ERR_W-1], err_ff}
                   - {last_error_ff[spdpid_pkg::ERR_W-1], last_error_ff};
   assign err_ext  = {{(spdpid_pkg::MCAND_W-spdpid_pkg::ERR_W){err_ff[spdpid_pkg::ERR_W-1]}},
                      err_ff};
   assign derr_ext = {{(spdpid_pkg::MCAND_W-spdpid_pkg::DERR_W){derr[spdpid_pkg::DERR_W-1]}},
                      derr};

   always_comb begin
      if (final_go) begin
         mul_a_mcand = integral_ff;
         mul_a_mplr  = gain_integral_ff;
      end else begin
         mul_a_mcand = err_ext;
         mul_a_mplr  = {1'b0, dt_ff};
      end
   end

   spdpid_mul u_mul_a (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_go | final_go),
      .multiplicand (mul_a_mcand),
      .multiplier   (mul_a_mplr),
      .done         (mul_a_done),
      .product      (prod_a)
   );

   spdpid_mul u_mul_b (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_go),
      .multiplicand (err_ext),
      .multiplier   (gain_prop_ff),
      .done         (mul_b_done),
      .product      (prod_b)
   );

   spdpid_mul u_mul_c (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_go),
      .multiplicand (derr_ext),
      .multiplier   (gain_deriv_ff),
      .done         (mul_c_done),
      .product      (prod_c)
   );

   // ------------------------------------------------------------------
   // Integral update with symmetric saturation. The previous error is taken
   // over at the same time; both clear when the motor is stopped.
   // ------------------------------------------------------------------
   logic signed [spdpid_pkg::ACC_W-1:0] acc_raw;
   logic signed [spdpid_pkg::ACC_W-1:0] lim_pos;
   logic signed [spdpid_pkg::ACC_W-1:0] lim_neg;
   logic signed [spdpid_pkg::ACC_W-1:0] acc_clamped;

   always_comb begin
      acc_raw = {{(spdpid_pkg::ACC_W-spdpid_pkg::INTEG_W){integral_ff[spdpid_pkg::INTEG_W-1]}},
                 integral_ff} + prod_a[spdpid_pkg::ACC_W-1:0];
      lim_pos = {{(spdpid_pkg::ACC_W-spdpid_pkg::LIMIT_W){1'b0}}, integral_limit_ff};
      lim_neg = -lim_pos;
      if (acc_raw > lim_pos) begin
         acc_clamped = lim_pos;
      end else if (acc_raw < lim_neg) begin
         acc_clamped = lim_neg;
      end else begin
         acc_clamped = acc_raw;
      end

      integral_in   = integral_ff;
      last_error_in = last_error_ff;
      if (clear_en) begin
         integral_in   = '0;
         last_error_in = '0;
      end else if (clamp_en) begin
         integral_in   = acc_clamped[spdpid_pkg::INTEG_W-1:0];
         last_error_in = err_ff;
      end
   end

   // ------------------------------------------------------------------
   // Derivative division: magnitude through the divider, sign reapplied, so
   // the quotient truncates toward zero. A zero time step divides by one.
   // ------------------------------------------------------------------
   logic                                   dneg_ff, dneg_in;
   logic        [spdpid_pkg::PROD_W-1:0]   dmag_full;
   logic        [spdpid_pkg::DIVISOR_W-1:0] divisor;
   logic        [spdpid_pkg::DIVIDEND_W-1:0] quotient;

   assign dmag_full = prod_c[spdpid_pkg::PROD_W-1] ? (~prod_c + 1'b1) : prod_c;
   assign divisor   = (dt_ff == '0) ? spdpid_pkg::DIVISOR_W'(1) : dt_ff;
   assign dneg_in   = final_go ? prod_c[spdpid_pkg::PROD_W-1] : dneg_ff;

   spdpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (final_go),
      .dividend (dmag_full[spdpid_pkg::DIVIDEND_W-1:0]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // ------------------------------------------------------------------
   // Sum of the three terms, floored at zero.
   // ------------------------------------------------------------------
   logic signed [spdpid_pkg::SUM_W-1:0] p_term, i_term, d_mag, d_term, sum_all;
   logic        [spdpid_pkg::MAG_W-1:0] sum_ff, sum_in;

   always_comb begin
      p_term  = {{(spdpid_pkg::SUM_W-spdpid_pkg::PROD_W){prod_b[spdpid_pkg::PROD_W-1]}}, prod_b};
      i_term  = {{(spdpid_pkg::SUM_W-spdpid_pkg::PROD_W){prod_a[spdpid_pkg::PROD_W-1]}}, prod_a};
      d_mag   = {{(spdpid_pkg::SUM_W-spdpid_pkg::DIVIDEND_W){1'b0}}, quotient};
      d_term  = dneg_ff ? -d_mag : d_mag;
      sum_all = p_term + i_term + d_term;
      sum_in  = sum_ff;
      if (sum_en) begin
         sum_in = sum_all[spdpid_pkg::SUM_W-1] ? '0 : sum_all[spdpid_pkg::MAG_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Duty mapping: shift, add the floor, clamp to the ceiling, then raise to
   // the floor so that the floor wins when the ceiling lies below it.
   // ------------------------------------------------------------------
   logic [spdpid_pkg::MAG_W-1:0]  shifted;
   logic                          shifted_big;
   logic [spdpid_pkg::DUTY_W:0]   duty_raw;
   logic [spdpid_pkg::DUTY_W-1:0] duty_capped;
   logic [spdpid_pkg::DUTY_W-1:0] duty_run;

   always_comb begin
      shifted     = sum_ff >> frac_shift_ff;
      shifted_big = |shifted[spdpid_pkg::MAG_W-1:spdpid_pkg::DUTY_W];
      duty_raw    = {1'b0, shifted[spdpid_pkg::DUTY_W-1:0]} + {1'b0, duty_floor_ff};
      if (shifted_big || (duty_raw > {1'b0, duty_ceiling_ff})) begin
         duty_capped = duty_ceiling_ff;
      end else begin
         duty_capped = duty_raw[spdpid_pkg::DUTY_W-1:0];
      end
      duty_run = (duty_capped < duty_floor_ff) ? duty_floor_ff : duty_capped;
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spdpid_pkg::DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic                          rsp_stop_ff, rsp_stop_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_stop_in  = rsp_stop_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_duty_in  = stop_ff ? '0 : duty_run;
         rsp_stop_in  = stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spdpid_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         integral_ff   <= '0;
         last_error_ff <= '0;
         stop_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         integral_ff   <= integral_in;
         last_error_ff <= last_error_in;
         stop_ff       <= stop_in;
      end
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      dneg_ff     <= dneg_in;
      sum_ff      <= sum_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty       = rsp_duty_ff;
   assign rsp_motor_stop = rsp_stop_ff;

endmodule

/* rtl/spdpid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed PID duty controller checker
// Port-level assertions on the item channels of the controller core.
// ----------------------------------------------------------------------------
module spdpid_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [spdpid_pkg::DUTY_W-1:0]     rsp_duty,
   input logic                              rsp_motor_stop
);

   // Items accepted but not yet delivered.
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // At most one item in work and one waiting in the output register.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two items outstanding");

   // A result never shows up without an item behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

   // Items are worked on one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken in back-to-back cycles");

   // A stopped motor always reports zero duty.
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_stop) |-> rsp_duty == '0)
      else $error("nonzero duty with motor stopped");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_duty)
                                    && $stable(rsp_motor_stop))
      else $error("stalled result changed");

endmodule

bind speed_pid_duty_controller_core spdpid_checker u_spdpid_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_duty       (rsp_duty),
   .rsp_motor_stop (rsp_motor_stop)
);
